// File: sv/bdn_pkg.sv
package bdn_pkg;

    localparam int DATA_W       = 8;
    localparam int CFG_W        = 11;
    localparam int MAX_LINE_DEF = 1024;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(640);

    typedef logic [DATA_W-1:0] t_pix;

endpackage

// File: sv/bdn_ram.sv
module bdn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bayer_nearest_demosaic.sv
// An accepted beat goes to the s1 registers, then to the output registers.
// One beat per cycle unless the output stalls; the line store is read and
// written at the same column in the accept cycle, so no forwarding is needed.
// Reset (synchronous, active low): held colors, column and row parity clear,
// first-row flag sets, line width returns to 640; the line store is not cleared.
module bayer_nearest_demosaic
    import bdn_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_line_width,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_sample,
    input  logic              i_frame_start,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_red,
    output logic [DATA_W-1:0] o_green,
    output logic [DATA_W-1:0] o_blue
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE);

    logic [CFG_W-1:0] r_line_width;
    logic [CW-1:0]    r_column, n_column;
    logic             r_row_odd, n_row_odd;
    logic             r_first, n_first;

    logic             r_s1_valid;
    t_pix             r_s1_sample;
    logic             r_s1_col_odd;
    logic             r_s1_row_odd;
    logic             r_s1_first;

    logic             r_out_valid;
    t_pix             r_red, r_green, r_blue;
    t_pix             n_red, n_green, n_blue;

    logic             in_acc;
    logic             s1_adv;
    logic [CW-1:0]    col;
    logic             row_odd;
    logic             first;
    logic [WW-1:0]    w_ext;
    logic [WW-1:0]    w_eff;
    logic             row_end;
    t_pix             ram_q;
    t_pix             above;

    assign o_cfg_ready = 1'b1;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign col     = i_frame_start ? '0 : r_column;
    assign row_odd = i_frame_start ? 1'b0 : r_row_odd;
    assign first   = i_frame_start ? 1'b1 : r_first;

    assign w_ext = WW'(r_line_width);
    assign w_eff = (w_ext == '0) ? WW'(1) : ((w_ext > MAX_W) ? MAX_W : w_ext);
    assign row_end = (WW'(col) + WW'(1)) >= w_eff;

    always_comb begin
        n_column  = r_column;
        n_row_odd = r_row_odd;
        n_first   = r_first;
        if (in_acc) begin
            if (row_end) begin
                n_column  = '0;
                n_row_odd = !row_odd;
                n_first   = 1'b0;
            end else begin
                n_column  = col + CW'(1);
                n_row_odd = row_odd;
                n_first   = first;
            end
        end
    end

    bdn_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_LINE)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (col),
        .i_wdata (i_sample),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (ram_q)
    );

    assign above = r_s1_first ? r_s1_sample : ram_q;

    always_comb begin
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        unique case ({r_s1_row_odd, r_s1_col_odd})
            2'b00: begin
                n_green = r_s1_sample;
                n_blue  = above;
            end
            2'b01: begin
                n_red = r_s1_sample;
            end
            2'b10: begin
                n_blue = r_s1_sample;
            end
            2'b11: begin
                n_green = r_s1_sample;
                n_red   = above;
            end
            default: begin
                n_red = r_red;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_column     <= '0;
            r_row_odd    <= 1'b0;
            r_first      <= 1'b1;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_red        <= '0;
            r_green      <= '0;
            r_blue       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_line_width <= i_cfg_line_width;
            end
            r_column  <= n_column;
            r_row_odd <= n_row_odd;
            r_first   <= n_first;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_red       <= n_red;
                r_green     <= n_green;
                r_blue      <= n_blue;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample  <= i_sample;
            r_s1_col_odd <= col[0];
            r_s1_row_odd <= row_odd;
            r_s1_first   <= first;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_column) < MAX_W)
        else $error("column beyond line store");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("stall without full pipeline");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_frame_start |=> r_s1_valid && r_s1_first && !r_s1_row_odd
            && !r_s1_col_odd)
        else $error("frame start not restarting position");

    a_first_row_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_first && !r_s1_row_odd && !r_s1_col_odd
            |=> o_out_valid && (o_green == o_blue))
        else $error("first row blue not taken from sample");

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && row_end |=> (r_column == '0) && !r_first)
        else $error("row end did not wrap column");

endmodule

// File: tb/tb_top.sv
module tb_top
    import bdn_pkg::*;
;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    class demosaic_scoreboard;
        t_pix              held_red;
        t_pix              held_green;
        t_pix              held_blue;
        t_pix              line_mem [MAX_LINE_DEF];
        bit                line_seen [MAX_LINE_DEF];
        int unsigned       column;
        bit                row_odd;
        bit                first_row;
        logic [CFG_W-1:0]  line_width;
        t_rgb              pixel_q [$];
        int                errors;

        function new();
            held_red   = '0;
            held_green = '0;
            held_blue  = '0;
            column     = 0;
            row_odd    = 1'b0;
            first_row  = 1'b1;
            line_width = LINE_WIDTH_RST;
            errors     = 0;
        endfunction

        function void set_width(logic [CFG_W-1:0] w);
            line_width = w;
        endfunction

        function int unsigned eff_width();
            if (line_width == 0) return 1;
            if (line_width > MAX_LINE_DEF) return MAX_LINE_DEF;
            return line_width;
        endfunction

        function int unsigned cur_col();
            return (column >= MAX_LINE_DEF) ? MAX_LINE_DEF - 1 : column;
        endfunction

        // true when the next beat without a frame start would read a column never stored
        function bit reads_unwritten();
            return !first_row && !line_seen[cur_col()];
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void push_sample(t_pix s, logic fs);
            int unsigned col;
            t_pix        above;
            t_rgb        px;
            if (fs) begin
                column    = 0;
                row_odd   = 1'b0;
                first_row = 1'b1;
            end
            col   = cur_col();
            above = first_row ? s : line_mem[col];
            if (!row_odd) begin
                if (!col[0]) begin
                    held_green = s;
                    held_blue  = above;
                end else begin
                    held_red = s;
                end
            end else begin
                if (!col[0]) begin
                    held_blue = s;
                end else begin
                    held_green = s;
                    held_red   = above;
                end
            end
            line_mem[col]  = s;
            line_seen[col] = 1'b1;
            if (col + 1 >= eff_width()) begin
                column    = 0;
                row_odd   = ~row_odd;
                first_row = 1'b0;
            end else begin
                column = col + 1;
            end
            px.red   = held_red;
            px.green = held_green;
            px.blue  = held_blue;
            pixel_q.push_back(px);
        endfunction

        function void check_pixel(t_pix r, t_pix g, t_pix b);
            t_rgb exp_px;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel: r=%0h g=%0h b=%0h", r, g, b);
                return;
            end
            exp_px = pixel_q.pop_front();
            if (exp_px.red !== r || exp_px.green !== g || exp_px.blue !== b) begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: expected r=%0h g=%0h b=%0h, got r=%0h g=%0h b=%0h",
                             exp_px.red, exp_px.green, exp_px.blue, r, g, b);
            end
        endfunction
    endclass

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_line_width = '0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    t_pix              i_sample         = '0;
    logic              i_frame_start    = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b1;
    t_pix              o_red;
    t_pix              o_green;
    t_pix              o_blue;

    demosaic_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_done     = 0;
    int hold_left     = 0;

    logic [CFG_W-1:0] phase_width [12] = '{
        11'd4, 11'd1, 11'd2047, 11'd6, 11'd3, 11'd1024,
        11'd2, 11'd8, 11'd1025, 11'd5, 11'd0, 11'd16
    };

    bayer_nearest_demosaic i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_line_width (i_cfg_line_width),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .i_frame_start    (i_frame_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receive side: check beats, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pixel(o_red, o_green, o_blue);
        if (hold_asks != hold_done) begin
            hold_left = 60;
            hold_done = hold_asks;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_beat(input t_pix s, input logic fs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample      <= s;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.push_sample(s, fs);
    endtask

    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_width(input logic [CFG_W-1:0] w);
        i_cfg_valid      <= 1'b1;
        i_cfg_line_width <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_width(w);
    endtask

    task automatic send_random(input int count, input bit restart);
        t_pix s;
        logic fs;
        for (int k = 0; k < count; k++) begin
            s  = t_pix'($urandom_range(0, 255));
            fs = (k == 0 && restart) || ($urandom_range(0, 39) == 0);
            if (sb.reads_unwritten()) fs = 1'b1;
            send_beat(s, fs);
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 28;
        recv_idle_pct = 63;
        @(posedge i_clk);

        // reset width, no frame start yet, then restart mid-row
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hA5, 1'b0);
        send_beat(8'h5A, 1'b1);
        drain_outputs();

        // zero width acts as one: every beat ends a row
        write_line_width(11'd0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h81, 1'b0);
        send_beat(8'h7E, 1'b0);
        drain_outputs();

        // all four Bayer positions with a line above
        write_line_width(11'd2);
        send_beat(8'h11, 1'b1);
        send_beat(8'h22, 1'b0);
        send_beat(8'h33, 1'b0);
        send_beat(8'h44, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        drain_outputs();

        // saturated width, then shrink below the current column
        write_line_width(11'd2047);
        send_beat(8'h01, 1'b1);
        for (int k = 0; k < 5; k++) send_beat(t_pix'(8'h10 << (k % 4)), 1'b0);
        drain_outputs();
        write_line_width(11'd3);
        for (int k = 0; k < 4; k++) send_beat(t_pix'($urandom_range(0, 255)), 1'b0);
        drain_outputs();

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                send_idle_pct = 63;
                recv_idle_pct = 28;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_line_width(phase_width[p]);
            n = (sb.eff_width() >= 64) ? 12 : 44;
            if (p == 2 || p == 9) begin
                send_random(n / 4, 1'b1);
                if (p == 9) begin
                    hold_asks++;
                end else begin
                    drain_outputs();
                end
                send_random(n - n / 4, 1'b0);
            end else begin
                send_random(n, $urandom_range(0, 1));
            end
            drain_outputs();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/bdn_pkg.sv
sv/bdn_ram.sv
sv/bayer_nearest_demosaic.sv
tb/tb_top.sv
